// ----- sv/dht_pkg.sv -----
// ----------------------------------------------------------------------------
// dht_pkg
// Shared constants and types of the direct Hilbert transform unit.
// ----------------------------------------------------------------------------
package dht_pkg;

  // Field widths fixed by the item format
  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 10;
  localparam int CFG_W    = 11;
  localparam int OUT_W    = 24;

  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  localparam logic [CFG_W-1:0] CFG_COUNT_RESET = 11'd1024;

  // round(2^64 / pi)
  localparam logic [63:0] INV_PI_Q64 = 64'h517C_C1B7_2722_0A95;

  // Item kinds
  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  // Sequencer to MAC control
  typedef struct packed {
    logic clr;  // clear accumulator
    logic vld;  // operands on the read ports form a term
    logic add;  // add term (n > k), else subtract
  } mac_ctrl_t;

endpackage

// ----- sv/direct_hilbert_transform_unit.sv -----
// ----------------------------------------------------------------------------
// direct_hilbert_transform_unit
// Direct discrete Hilbert transform over a stored block of samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): a write item (kind 0) stores
//   in_sample_i at in_index_i and gives no result; indexes at or above
//   MAX_SAMPLES are dropped. A compute item (kind 1) returns y[n] for
//   n = in_index_i, summed over the first sample_count samples.
//   Output channel (out_valid_o / out_stall_i): one item per compute.
//   Config channel (cfg_valid_i / cfg_ready_o): writes sample_count; ready is
//   always high. Write it only while the block is idle.
// Timing:
//   Write items: one per cycle while no compute is in progress. A compute item
//   runs one term per cycle through the shared multiply-accumulate unit
//   (count = min(sample_count, MAX_SAMPLES), the term with k = n skipped) plus
//   read, product, drain and round/saturate steps; in_stall_o is high until
//   its result is loaded into the output register.
// Reset: sample_count returns to 1024, the sequencer to idle, no item pending.
//   Samples are undefined until written.
// Output stall: the result sits in an output register; writes continue to be
//   taken, and a following compute waits at its last step until it frees.
// ----------------------------------------------------------------------------
module direct_hilbert_transform_unit
  import dht_pkg::*;
#(
  parameter int MAX_SAMPLES    = 1024,
  parameter int COEF_FRAC_BITS = 18
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input items
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       in_kind_i,
  input  logic [INDEX_W-1:0]         in_index_i,
  input  logic signed [SAMPLE_W-1:0] in_sample_i,
  // result items
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [INDEX_W-1:0]         out_index_o,
  output logic signed [OUT_W-1:0]    out_transformed_o,
  // configuration
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_W-1:0]           cfg_data_i
);

  localparam int SAW    = $clog2(MAX_SAMPLES);
  localparam int KW     = $clog2(MAX_SAMPLES + 1);
  localparam int CDEPTH = (MAX_SAMPLES > 1024) ? MAX_SAMPLES : 1024;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int DW     = CAW + 1;
  localparam int CW     = COEF_FRAC_BITS - 1;

  typedef enum logic [1:0] {StIdle, StRun, StDrain, StFin} state_e;

  state_e              state_q;
  logic [CFG_W-1:0]    sample_count_q;
  logic [INDEX_W-1:0]  n_q;
  logic [KW-1:0]       k_q, cnt_q, cnt_eff;
  logic                s1_v_q, s1_add_q;
  logic                out_valid_q;
  logic [INDEX_W-1:0]  out_index_q;
  logic signed [OUT_W-1:0] out_data_q;

  logic                in_acc, start, wr_en, issue, out_free;
  logic [31:0]         idx32;
  logic [DW-1:0]       n_ext, k_ext, diff, delta;
  logic                n_gt_k, n_eq_k;
  logic signed [SAMPLE_W-1:0] ram_rdata;
  logic [CW-1:0]       coef;
  logic                mac_busy;
  logic signed [OUT_W-1:0] mac_result;
  mac_ctrl_t           mac_ctrl;

  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign start       = in_acc && (in_kind_i == KIND_COMPUTE);
  assign idx32       = 32'(in_index_i);
  assign wr_en       = in_acc && (in_kind_i == KIND_WRITE) &&
                       (idx32 < 32'(MAX_SAMPLES));
  assign cnt_eff     = (32'(sample_count_q) > 32'(MAX_SAMPLES)) ?
                       KW'(MAX_SAMPLES) : KW'(sample_count_q);

  assign issue   = (state_q == StRun) && (k_q != cnt_q);
  assign n_ext   = DW'(n_q);
  assign k_ext   = DW'(k_q);
  assign diff    = n_ext - k_ext;
  assign n_gt_k  = n_ext > k_ext;
  assign n_eq_k  = n_ext == k_ext;
  assign delta   = n_gt_k ? diff : (k_ext - n_ext);
  assign out_free = !out_valid_q || !out_stall_i;

  assign mac_ctrl.clr = start;
  assign mac_ctrl.vld = s1_v_q;
  assign mac_ctrl.add = s1_add_q;

  dht_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_SAMPLES)
  ) u_samples (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (idx32[SAW-1:0]),
    .wdata_i (in_sample_i),
    .raddr_i (k_q[SAW-1:0]),
    .rdata_o (ram_rdata)
  );

  dht_coef_rom #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .DEPTH          (CDEPTH)
  ) u_coef (
    .clk_i  (clk_i),
    .addr_i (delta[CAW-1:0]),
    .coef_o (coef)
  );

  dht_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .CNT_BITS       (SAW)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (ram_rdata),
    .coef_i   (coef),
    .busy_o   (mac_busy),
    .result_o (mac_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      sample_count_q <= CFG_COUNT_RESET;
      k_q            <= '0;
      cnt_q          <= '0;
      s1_v_q         <= 1'b0;
      s1_add_q       <= 1'b0;
      out_valid_q    <= 1'b0;
      n_q            <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        sample_count_q <= cfg_data_i;
      end
      s1_v_q   <= issue && !n_eq_k;
      s1_add_q <= n_gt_k;
      if (state_q == StFin && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (start) begin
            n_q     <= in_index_i;
            cnt_q   <= cnt_eff;
            k_q     <= '0;
            state_q <= StRun;
          end
        end
        StRun: begin
          if (issue) begin
            k_q <= k_q + KW'(1);
          end else begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          if (!s1_v_q && !mac_busy) begin
            state_q <= StFin;
          end
        end
        StFin: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StFin && out_free) begin
      out_index_q <= n_q;
      out_data_q  <= mac_result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_index_o       = out_index_q;
  assign out_transformed_o = out_data_q;

`ifndef ASSERT_OFF
  a_start_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> in_stall_o)
    else $error("compute item accepted but input not stalled");

  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= cnt_q)
    else $error("term counter ran past sample count");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (!s1_v_q && !mac_busy))
    else $error("terms in flight while idle");

  a_load_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q ##1 out_valid_q) |-> $past(state_q == StFin))
    else $error("result loaded outside final step");
`endif

endmodule

// ----- sv/dht_ram.sv -----
// ----------------------------------------------------------------------------
// dht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dht_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/dht_coef_rom.sv -----
// ----------------------------------------------------------------------------
// dht_coef_rom
// Coefficient ROM: c[d] = round(2^F / (pi * d)), entry 0 unused. Registered read.
// ----------------------------------------------------------------------------
module dht_coef_rom
  import dht_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 18,
  parameter int DEPTH          = 1024
) (
  input  logic                        clk_i,
  input  logic [$clog2(DEPTH)-1:0]    addr_i,
  output logic [COEF_FRAC_BITS-2:0]   coef_o
);

  localparam int CW = COEF_FRAC_BITS - 1;
  // 2^(F+32) / pi
  localparam logic [63:0] XQ = INV_PI_Q64 >> (32 - COEF_FRAC_BITS);

  logic [CW-1:0] tbl [DEPTH];
  logic [CW-1:0] coef_q;

  for (genvar g = 0; g < DEPTH; g++) begin : g_coef
    localparam logic [63:0] NUM = XQ + (64'(g) << 31);
    localparam logic [63:0] DEN = (g == 0) ? 64'd1 : (64'(g) << 32);
    localparam logic [63:0] VAL = (g == 0) ? 64'd0 : NUM / DEN;
    assign tbl[g] = VAL[CW-1:0];
  end

  always_ff @(posedge clk_i) begin
    coef_q <= tbl[addr_i];
  end

  assign coef_o = coef_q;

endmodule

// ----- sv/dht_mac.sv -----
// ----------------------------------------------------------------------------
// dht_mac
// Shared multiply-accumulate unit with round-half-up shift and 24-bit saturation.
// ----------------------------------------------------------------------------
module dht_mac
  import dht_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 18,
  parameter int CNT_BITS       = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mac_ctrl_t                   ctrl_i,
  input  logic signed [SAMPLE_W-1:0]  sample_i,
  input  logic [COEF_FRAC_BITS-2:0]   coef_i,
  output logic                        busy_o,
  output logic signed [OUT_W-1:0]     result_o
);

  localparam int CW  = COEF_FRAC_BITS - 1;
  localparam int PW  = SAMPLE_W + CW + 1;
  localparam int ACW = PW + CNT_BITS;
  localparam int RW  = ACW + 1;

  localparam logic signed [RW-1:0] HALF   = RW'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [RW-1:0] SAT_HI = RW'(OUT_MAX);
  localparam logic signed [RW-1:0] SAT_LO = RW'(OUT_MIN);

  logic signed [PW-1:0]  prod_d, prod_q;
  logic                  p_v_q, p_add_q;
  logic signed [ACW-1:0] acc_q, term;
  logic signed [RW-1:0]  rnd, yv;

  assign prod_d = sample_i * $signed({1'b0, coef_i});
  assign term   = ACW'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else begin
      p_v_q <= ctrl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    p_add_q <= ctrl_i.add;
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (p_v_q) begin
      acc_q <= p_add_q ? acc_q + term : acc_q - term;
    end
  end

  // floor((acc + half) / 2^F), then clamp
  assign rnd = RW'(acc_q) + HALF;
  assign yv  = rnd >>> COEF_FRAC_BITS;

  always_comb begin
    if (yv > SAT_HI) begin
      result_o = OUT_W'(SAT_HI);
    end else if (yv < SAT_LO) begin
      result_o = OUT_W'(SAT_LO);
    end else begin
      result_o = yv[OUT_W-1:0];
    end
  end

  assign busy_o = p_v_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the direct Hilbert transform unit. The low sample
// slots are loaded first, then directed and random write/compute traffic runs
// over sample counts that stay inside the loaded slots (0, 1, 2, small, medium,
// the whole loaded range) with random gaps on the input side and random stalls
// on the result side. Each result is checked against an in-bench fixed point
// model of the transform.
// ----------------------------------------------------------------------------
module tb_top
  import dht_pkg::*;
();

  localparam int DEPTH = 1024;
  localparam int FRAC  = 18;
  // slots loaded before any request; counts never go past this
  localparam int FILL  = 256;

  typedef struct {
    logic [INDEX_W-1:0]      pos;
    logic signed [OUT_W-1:0] value;
  } hilbert_out_t;

  class hilbert_scoreboard;
    logic signed [SAMPLE_W-1:0] store [DEPTH];
    longint unsigned            coef [DEPTH];
    logic [CFG_W-1:0]           sum_count;
    hilbert_out_t               pending [$];
    int unsigned                errors;
    int unsigned                checked;

    function new();
      longint unsigned x;
      longint unsigned dd;
      // 2^(FRAC+32)/pi, then c[d] = round-to-nearest of x / (d * 2^32)
      x = INV_PI_Q64 >> (32 - FRAC);
      coef[0] = 0;
      for (int d = 1; d < DEPTH; d++) begin
        dd = 64'(d);
        coef[d] = (x + (dd << 31)) / (dd << 32);
      end
      foreach (store[i]) store[i] = '0;
      sum_count = CFG_COUNT_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function logic signed [OUT_W-1:0] hilbert_at(logic [INDEX_W-1:0] n);
      int unsigned terms;
      longint acc;
      longint y;
      terms = (sum_count > DEPTH) ? DEPTH : sum_count;
      acc = 0;
      for (int unsigned k = 0; k < terms; k++) begin
        if (k == n) continue;
        if (n > k) acc += longint'(store[k]) * longint'(coef[n - k]);
        else       acc -= longint'(store[k]) * longint'(coef[k - n]);
      end
      // round half up, then floor shift
      y = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
      if (y > OUT_MAX) y = OUT_MAX;
      if (y < OUT_MIN) y = OUT_MIN;
      return y[OUT_W-1:0];
    endfunction

    function void note_item(logic kind, logic [INDEX_W-1:0] pos,
                            logic signed [SAMPLE_W-1:0] smp);
      hilbert_out_t e;
      if (kind == KIND_WRITE) begin
        store[pos] = smp;
      end else begin
        e.pos   = pos;
        e.value = hilbert_at(pos);
        pending.push_back(e);
      end
    endfunction

    function void check_result(logic [INDEX_W-1:0] pos, logic signed [OUT_W-1:0] value);
      hilbert_out_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: result without request: expected none, actual index %0d value %0d",
                 $time, pos, value);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (pos !== e.pos) begin
        $display("%0t: out_index mismatch: expected %0d, actual %0d", $time, e.pos, pos);
        errors++;
      end
      if (value !== e.value) begin
        $display("%0t: transformed mismatch at n=%0d: expected %0d, actual %0d",
                 $time, e.pos, e.value, value);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       in_kind_i = KIND_WRITE;
  logic [INDEX_W-1:0]         in_index_i = '0;
  logic signed [SAMPLE_W-1:0] in_sample_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [INDEX_W-1:0]         out_index_o;
  logic signed [OUT_W-1:0]    out_transformed_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_W-1:0]           cfg_data_i = '0;

  hilbert_scoreboard sb;
  bit                in_calm = 1'b0;
  bit                out_calm = 1'b0;
  int unsigned       out_hold = 0;
  int unsigned       items_sent = 0;
  int unsigned       cfg_writes = 0;

  always #10 clk_i = ~clk_i;

  direct_hilbert_transform_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_kind_i         (in_kind_i),
    .in_index_i        (in_index_i),
    .in_sample_i       (in_sample_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_index_o       (out_index_o),
    .out_transformed_o (out_transformed_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i)
  );

  // Result side: after each result is taken, the next one is held off for a freshly drawn number of cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_index_o, out_transformed_o);
        out_hold = out_calm ? 0 : $urandom_range(0, 7);
      end else if (out_valid_o && out_hold != 0) begin
        out_hold--;
      end
      out_stall_i <= (out_hold != 0);
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] any_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // mostly inside the summed range, sometimes anywhere
  function automatic logic [INDEX_W-1:0] pick_pos(int unsigned eff);
    if (eff != 0 && $urandom_range(0, 3) != 0) return INDEX_W'($urandom_range(0, eff - 1));
    return INDEX_W'($urandom_range(0, DEPTH - 1));
  endfunction

  // valid stays high after acceptance so a zero gap keeps it up
  task automatic send_item(logic kind, logic [INDEX_W-1:0] pos,
                           logic signed [SAMPLE_W-1:0] smp);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_kind_i   <= kind;
    in_index_i  <= pos;
    in_sample_i <= smp;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(kind, pos, smp);
    items_sent++;
  endtask

  // drain all results, then let trailing writes settle
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CFG_W-1:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.sum_count = value;
    cfg_writes++;
  endtask

  task automatic run_phase(logic [CFG_W-1:0] count, int unsigned n_items,
                           int unsigned compute_pct);
    int unsigned first;
    int unsigned eff;
    int unsigned n_wr;
    int unsigned n_cm;
    write_count(count);
    in_calm  = ($urandom_range(0, 3) == 0);
    out_calm = ($urandom_range(0, 3) == 0);
    eff = (count > DEPTH) ? DEPTH : count;
    first = items_sent;
    while (items_sent - first < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item(1'($urandom_range(0, 1)), INDEX_W'($urandom_range(0, DEPTH - 1)),
                  any_sample());
      end else begin
        // a few sample updates, then requests against them
        n_wr = $urandom_range(1, 6);
        n_cm = ($urandom_range(0, 99) < compute_pct) ? $urandom_range(1, 2) : 0;
        repeat (n_wr) send_item(KIND_WRITE, pick_pos(eff), any_sample());
        repeat (n_cm) send_item(KIND_COMPUTE, pick_pos(eff), any_sample());
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // load the low slots so no request ever reads an unwritten sample
    in_calm = 1'b1;
    for (int k = 0; k < FILL; k++) begin
      send_item(KIND_WRITE, INDEX_W'(k), (k == 0) ? 16'h7FFF :
                                         (k == FILL - 1) ? 16'h8000 : any_sample());
    end
    in_calm = 1'b0;

    // whole loaded range, end positions and extreme samples
    write_count(CFG_W'(FILL));
    send_item(KIND_COMPUTE, '0, any_sample());
    send_item(KIND_COMPUTE, INDEX_W'(FILL - 1), any_sample());
    send_item(KIND_COMPUTE, INDEX_W'(DEPTH - 1), any_sample());
    send_item(KIND_COMPUTE, INDEX_W'(FILL / 2), any_sample());
    send_item(KIND_WRITE, '0, 16'h8000);
    send_item(KIND_WRITE, INDEX_W'(FILL - 1), 16'h7FFF);
    send_item(KIND_COMPUTE, '0, any_sample());
    send_item(KIND_COMPUTE, INDEX_W'(FILL - 1), any_sample());
    send_item(KIND_COMPUTE, INDEX_W'(1), any_sample());
    // single sample; positions at and beyond the count
    write_count(CFG_W'(1));
    send_item(KIND_COMPUTE, '0, any_sample());
    send_item(KIND_COMPUTE, INDEX_W'(1), any_sample());
    send_item(KIND_COMPUTE, INDEX_W'(DEPTH - 1), any_sample());
    // empty sum
    write_count('0);
    send_item(KIND_COMPUTE, INDEX_W'(5), any_sample());
    send_item(KIND_COMPUTE, '0, any_sample());
    write_count(CFG_W'(2));
    send_item(KIND_WRITE, INDEX_W'(1), 16'h7FFF);
    send_item(KIND_COMPUTE, '0, any_sample());
    send_item(KIND_COMPUTE, INDEX_W'(1), any_sample());
    send_item(KIND_COMPUTE, INDEX_W'(2), any_sample());

    // random traffic; large counts get fewer requests to bound run time
    run_phase(CFG_W'(1), 30, 100);
    run_phase(CFG_W'(2), 30, 100);
    run_phase(CFG_W'($urandom_range(3, 16)), 30, 100);
    run_phase(CFG_W'($urandom_range(17, 64)), 30, 80);
    run_phase(CFG_W'($urandom_range(65, FILL)), 30, 50);
    run_phase('0, 30, 100);
    run_phase(CFG_W'(FILL), 30, 40);
    run_phase(CFG_W'($urandom_range(3, 16)), 30, 100);
    run_phase(CFG_W'($urandom_range(17, 64)), 30, 100);
    run_phase(CFG_W'(FILL), 30, 40);

    settle();
    $display("Covered %0d items with %0d transform results checked over %0d count writes,",
             items_sent, sb.checked, cfg_writes);
    $display("counts from 0 to %0d, random input gaps and result stalls.", FILL);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
